// ----- rtl/core/geg_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Grain envelope generator package
// Shared widths, controller states, datapath operations and helper functions.
// ---------------------------------------------------------------------------
package geg_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int LENGTH_BITS   = 16;
   localparam int ACC_FRAC_BITS = 30;
   localparam int ACC_BITS      = ACC_FRAC_BITS + 10;
   localparam int LEVEL_BITS    = 17;
   localparam int MUL_BITS      = 34;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int DIVIDEND_BITS = 50;
   localparam int DIVISOR_BITS  = 32;
   localparam int DIV_CNT_BITS  = 6;

   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   localparam logic [1:0] KIND_PARABOLIC = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE  = 2'd1;
   localparam logic [1:0] KIND_BELL      = 2'd2;
   localparam logic [1:0] KIND_UNITY     = 2'd3;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE, ST_DISPATCH,
      ST_MAP_S, ST_MAP_K, ST_INIT,
      ST_P_SQ, ST_P_NUM, ST_P_DIV1, ST_P_W1, ST_P_DIV2, ST_P_W2, ST_P_END,
      ST_T_MID, ST_T_DIV1, ST_T_W1, ST_T_DIV2, ST_T_W2, ST_T_END,
      ST_B_MULK, ST_B_K2, ST_B_SRL, ST_B_SUS, ST_B_ATT, ST_B_W1, ST_B_RISE,
      ST_B_W2, ST_B_FALL,
      ST_S_PAR, ST_S_TRI, ST_S_UNIT, ST_S_BELL1, ST_S_BELL2, ST_S_BELL3,
      ST_OUT1, ST_OUT2
   } ctrl_state_type;

   typedef enum logic [5:0] {
      OP_NONE,
      OP_MAP_S, OP_MAP_K, OP_INIT,
      OP_P_SQ, OP_P_NUM, OP_P_DIV1, OP_P_DIV2, OP_P_END,
      OP_T_MID, OP_T_DIV1, OP_T_DIV2, OP_T_END,
      OP_B_MULK, OP_B_K2, OP_B_SRL, OP_B_SUS, OP_B_ATT, OP_B_RISE, OP_B_FALL,
      OP_S_PAR, OP_S_TRI, OP_S_UNIT, OP_S_BELL1, OP_S_BELL2, OP_S_BELL3,
      OP_OUT1, OP_OUT2
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       cmd;
      logic [1:0] start_kind;
      logic [1:0] kind;
      logic       div_busy;
      logic       bell_flat;
      logic       out_busy;
   } dp_status_type;

   function automatic logic [ACC_BITS-1:0] acc_add_sat(input logic [ACC_BITS-1:0] a,
                                                       input logic [ACC_BITS-1:0] b);
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
      if (s[ACC_BITS] != s[ACC_BITS-1])
         return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      return s[ACC_BITS-1:0];
   endfunction

   function automatic logic [ACC_BITS-1:0] acc_sub_sat(input logic [ACC_BITS-1:0] a,
                                                       input logic [ACC_BITS-1:0] b);
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
      if (s[ACC_BITS] != s[ACC_BITS-1])
         return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      return s[ACC_BITS-1:0];
   endfunction

   // quotient to accumulator step, full range on zero divisor or overflow
   function automatic logic [ACC_BITS-1:0] acc_from_quo(input logic [DIVIDEND_BITS-1:0] q,
                                                        input logic zero);
      if (zero || (q[DIVIDEND_BITS-1:ACC_BITS-1] != '0))
         return ACC_MAX;
      return {1'b0, q[ACC_BITS-2:0]};
   endfunction

   function automatic logic [ACC_BITS-1:0] phase_from_quo(input logic [DIVIDEND_BITS-1:0] q,
                                                          input logic zero);
      if (zero)
         return {{(ACC_BITS-32){1'b0}}, 32'hFFFF_FFFF};
      return {{(ACC_BITS-32){1'b0}}, q[31:0]};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/geg_divider.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Grain envelope divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module geg_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [geg_pkg::DIVIDEND_BITS-1:0]   dividend,
   input  wire logic [geg_pkg::DIVISOR_BITS-1:0]    divisor,
   output logic                                     busy,
   output logic                                     divisor_zero,
   output logic [geg_pkg::DIVIDEND_BITS-1:0]        quotient
);

   logic [geg_pkg::DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [geg_pkg::DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [geg_pkg::DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [geg_pkg::DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [geg_pkg::DIVISOR_BITS:0]    shifted;
   logic [geg_pkg::DIVISOR_BITS:0]    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[geg_pkg::DIVIDEND_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = geg_pkg::DIV_CNT_BITS'(geg_pkg::DIVIDEND_BITS);
         rem_in = '0;
         dvs_in = divisor;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[geg_pkg::DIVISOR_BITS]) begin
            rem_in = diff[geg_pkg::DIVISOR_BITS-1:0];
            quo_in = {quo_ff[geg_pkg::DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[geg_pkg::DIVISOR_BITS-1:0];
            quo_in = {quo_ff[geg_pkg::DIVIDEND_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy         = (cnt_ff != '0);
   assign divisor_zero = (dvs_ff == '0);
   assign quotient     = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/geg_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Grain envelope controller
// Sequences start and sample transactions through the datapath.
// ---------------------------------------------------------------------------
module geg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire geg_pkg::dp_status_type status,
   output geg_pkg::ctrl_cmd_type       cmd
);

   geg_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         geg_pkg::ST_IDLE:     if (req_valid) state_in = geg_pkg::ST_DISPATCH;
         geg_pkg::ST_DISPATCH: begin
            if (status.cmd == geg_pkg::CMD_START) begin
               state_in = geg_pkg::ST_MAP_S;
            end else begin
               case (status.kind)
                  geg_pkg::KIND_PARABOLIC: state_in = geg_pkg::ST_S_PAR;
                  geg_pkg::KIND_TRIANGLE:  state_in = geg_pkg::ST_S_TRI;
                  geg_pkg::KIND_BELL:      state_in = geg_pkg::ST_S_BELL1;
                  default:                 state_in = geg_pkg::ST_S_UNIT;
               endcase
            end
         end
         geg_pkg::ST_MAP_S: state_in = geg_pkg::ST_MAP_K;
         geg_pkg::ST_MAP_K: state_in = geg_pkg::ST_INIT;
         geg_pkg::ST_INIT: begin
            case (status.start_kind)
               geg_pkg::KIND_PARABOLIC: state_in = geg_pkg::ST_P_SQ;
               geg_pkg::KIND_TRIANGLE:  state_in = geg_pkg::ST_T_MID;
               geg_pkg::KIND_BELL:      state_in = geg_pkg::ST_B_MULK;
               default:                 state_in = geg_pkg::ST_IDLE;
            endcase
         end
         geg_pkg::ST_P_SQ:   state_in = geg_pkg::ST_P_NUM;
         geg_pkg::ST_P_NUM:  state_in = geg_pkg::ST_P_DIV1;
         geg_pkg::ST_P_DIV1: state_in = geg_pkg::ST_P_W1;
         geg_pkg::ST_P_W1:   if (!status.div_busy) state_in = geg_pkg::ST_P_DIV2;
         geg_pkg::ST_P_DIV2: state_in = geg_pkg::ST_P_W2;
         geg_pkg::ST_P_W2:   if (!status.div_busy) state_in = geg_pkg::ST_P_END;
         geg_pkg::ST_P_END:  state_in = geg_pkg::ST_IDLE;
         geg_pkg::ST_T_MID:  state_in = geg_pkg::ST_T_DIV1;
         geg_pkg::ST_T_DIV1: state_in = geg_pkg::ST_T_W1;
         geg_pkg::ST_T_W1:   if (!status.div_busy) state_in = geg_pkg::ST_T_DIV2;
         geg_pkg::ST_T_DIV2: state_in = geg_pkg::ST_T_W2;
         geg_pkg::ST_T_W2:   if (!status.div_busy) state_in = geg_pkg::ST_T_END;
         geg_pkg::ST_T_END:  state_in = geg_pkg::ST_IDLE;
         geg_pkg::ST_B_MULK: state_in = geg_pkg::ST_B_K2;
         geg_pkg::ST_B_K2:   state_in = geg_pkg::ST_B_SRL;
         geg_pkg::ST_B_SRL:  state_in = geg_pkg::ST_B_SUS;
         geg_pkg::ST_B_SUS:  state_in = geg_pkg::ST_B_ATT;
         geg_pkg::ST_B_ATT:  state_in = geg_pkg::ST_B_W1;
         geg_pkg::ST_B_W1:   if (!status.div_busy) state_in = geg_pkg::ST_B_RISE;
         geg_pkg::ST_B_RISE: state_in = geg_pkg::ST_B_W2;
         geg_pkg::ST_B_W2:   if (!status.div_busy) state_in = geg_pkg::ST_B_FALL;
         geg_pkg::ST_B_FALL: state_in = geg_pkg::ST_IDLE;
         geg_pkg::ST_S_PAR:  state_in = geg_pkg::ST_OUT1;
         geg_pkg::ST_S_TRI:  state_in = geg_pkg::ST_OUT1;
         geg_pkg::ST_S_UNIT: state_in = geg_pkg::ST_OUT1;
         geg_pkg::ST_S_BELL1: begin
            if (status.bell_flat) state_in = geg_pkg::ST_OUT1;
            else                  state_in = geg_pkg::ST_S_BELL2;
         end
         geg_pkg::ST_S_BELL2: state_in = geg_pkg::ST_S_BELL3;
         geg_pkg::ST_S_BELL3: state_in = geg_pkg::ST_OUT1;
         geg_pkg::ST_OUT1:    state_in = geg_pkg::ST_OUT2;
         geg_pkg::ST_OUT2:    if (!status.out_busy) state_in = geg_pkg::ST_IDLE;
         default:             state_in = geg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == geg_pkg::ST_IDLE);
      cmd.load  = (state_ff == geg_pkg::ST_IDLE) && req_valid;
      case (state_ff)
         geg_pkg::ST_MAP_S:   cmd.op = geg_pkg::OP_MAP_S;
         geg_pkg::ST_MAP_K:   cmd.op = geg_pkg::OP_MAP_K;
         geg_pkg::ST_INIT:    cmd.op = geg_pkg::OP_INIT;
         geg_pkg::ST_P_SQ:    cmd.op = geg_pkg::OP_P_SQ;
         geg_pkg::ST_P_NUM:   cmd.op = geg_pkg::OP_P_NUM;
         geg_pkg::ST_P_DIV1:  cmd.op = geg_pkg::OP_P_DIV1;
         geg_pkg::ST_P_DIV2:  cmd.op = geg_pkg::OP_P_DIV2;
         geg_pkg::ST_P_END:   cmd.op = geg_pkg::OP_P_END;
         geg_pkg::ST_T_MID:   cmd.op = geg_pkg::OP_T_MID;
         geg_pkg::ST_T_DIV1:  cmd.op = geg_pkg::OP_T_DIV1;
         geg_pkg::ST_T_DIV2:  cmd.op = geg_pkg::OP_T_DIV2;
         geg_pkg::ST_T_END:   cmd.op = geg_pkg::OP_T_END;
         geg_pkg::ST_B_MULK:  cmd.op = geg_pkg::OP_B_MULK;
         geg_pkg::ST_B_K2:    cmd.op = geg_pkg::OP_B_K2;
         geg_pkg::ST_B_SRL:   cmd.op = geg_pkg::OP_B_SRL;
         geg_pkg::ST_B_SUS:   cmd.op = geg_pkg::OP_B_SUS;
         geg_pkg::ST_B_ATT:   cmd.op = geg_pkg::OP_B_ATT;
         geg_pkg::ST_B_RISE:  cmd.op = geg_pkg::OP_B_RISE;
         geg_pkg::ST_B_FALL:  cmd.op = geg_pkg::OP_B_FALL;
         geg_pkg::ST_S_PAR:   cmd.op = geg_pkg::OP_S_PAR;
         geg_pkg::ST_S_TRI:   cmd.op = geg_pkg::OP_S_TRI;
         geg_pkg::ST_S_UNIT:  cmd.op = geg_pkg::OP_S_UNIT;
         geg_pkg::ST_S_BELL1: cmd.op = geg_pkg::OP_S_BELL1;
         geg_pkg::ST_S_BELL2: cmd.op = geg_pkg::OP_S_BELL2;
         geg_pkg::ST_S_BELL3: cmd.op = geg_pkg::OP_S_BELL3;
         geg_pkg::ST_OUT1:    cmd.op = geg_pkg::OP_OUT1;
         geg_pkg::ST_OUT2:    cmd.op = status.out_busy ? geg_pkg::OP_NONE : geg_pkg::OP_OUT2;
         default:             cmd.op = geg_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= geg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/geg_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Grain envelope datapath
// Envelope state, one shared multiplier, the divider and the result register.
// ---------------------------------------------------------------------------
module geg_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire geg_pkg::ctrl_cmd_type                 cmd,
   output geg_pkg::dp_status_type                     status,
   input  wire logic                                  req_cmd,
   input  wire logic signed [geg_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic [1:0]                            req_env_kind,
   input  wire logic [geg_pkg::LENGTH_BITS-1:0]       req_grain_length,
   input  wire logic [15:0]                           req_length_ratio,
   input  wire logic [15:0]                           req_shape_amount,
   input  wire logic [15:0]                           req_skew_amount,
   input  wire logic [15:0]                           req_amplitude,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [geg_pkg::SAMPLE_BITS-1:0]     rsp_sample_out,
   output logic signed [geg_pkg::LEVEL_BITS-1:0]      rsp_envelope_level
);

   localparam int AB = geg_pkg::ACC_BITS;
   localparam int LB = geg_pkg::LENGTH_BITS;
   localparam int MB = geg_pkg::MUL_BITS;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [15:0] SHARE_SCALE = 16'd58982;
   localparam logic [15:0] SHARE_BASE  = 16'd3277;

   // latched transaction
   logic                       cmd_ff;
   logic signed [geg_pkg::SAMPLE_BITS-1:0] smp_ff;
   logic [1:0]                 kind_req_ff;
   logic [LB-1:0]              len_ff;
   logic [15:0]                ratio_ff, shape_ff, skew_ff, amp_ff;

   // envelope state
   logic [1:0]    kind_ff, kind_in;
   logic [15:0]   peak_ff, peak_in;
   logic [LB-1:0] cnt_ff, cnt_in;
   logic [AB-1:0] level_ff, level_in, slope_ff, slope_in, change_ff, change_in;
   logic [AB-1:0] rise_ff, rise_in, fall_ff, fall_in;
   logic [LB-1:0] att_end_ff, att_end_in, rel_start_ff, rel_start_in;
   logic [31:0]   rphase_ff, rphase_in, fphase_ff, fphase_in;

   // scratch
   logic [15:0]   shape_m_ff, shape_m_in, skew_m_ff, skew_m_in, k2_ff, k2_in;
   logic [LB-1:0] sus_ff, sus_in;
   logic [31:0]   sq_ff, sq_in;
   logic          neg_ff, neg_in;
   logic [geg_pkg::LEVEL_BITS-1:0] lev_ff, lev_in;
   logic signed [MB-1:0] mul_a, mul_b;
   logic signed [geg_pkg::PROD_BITS-1:0] prod_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [geg_pkg::SAMPLE_BITS-1:0] out_smp_ff, out_smp_in;
   logic [geg_pkg::LEVEL_BITS-1:0]  out_lev_ff, out_lev_in;

   // divider
   logic                               div_start, div_busy, div_zero;
   logic [geg_pkg::DIVIDEND_BITS-1:0]  div_dividend, div_quo;
   logic [geg_pkg::DIVISOR_BITS-1:0]   div_divisor;

   logic          in_attack, in_sustain;
   logic [31:0]   ph, p, mag, y;
   logic [32:0]   e33;
   logic [LB-1:0] mid_w, sus_w, att_w;
   logic [17:0]   k2_t;
   logic [24:0]   lvl_sh;
   logic [25:0]   ps;

   geg_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend     (div_dividend),
      .divisor      (div_divisor),
      .busy         (div_busy),
      .divisor_zero (div_zero),
      .quotient     (div_quo)
   );

   assign in_attack  = (cnt_ff < att_end_ff);
   assign in_sustain = !in_attack && (cnt_ff < rel_start_ff);

   always_comb begin
      kind_in      = kind_ff;
      peak_in      = peak_ff;
      cnt_in       = cnt_ff;
      level_in     = level_ff;
      slope_in     = slope_ff;
      change_in    = change_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      att_end_in   = att_end_ff;
      rel_start_in = rel_start_ff;
      rphase_in    = rphase_ff;
      fphase_in    = fphase_ff;
      shape_m_in   = shape_m_ff;
      skew_m_in    = skew_m_ff;
      k2_in        = k2_ff;
      sus_in       = sus_ff;
      sq_in        = sq_ff;
      neg_in       = neg_ff;
      lev_in       = lev_ff;
      out_smp_in   = out_smp_ff;
      out_lev_in   = out_lev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      mid_w  = prod_ff[31:16];
      sus_w  = prod_ff[47:32];
      att_w  = prod_ff[31:16];
      k2_t   = prod_ff[33:16];
      ph     = in_attack ? rphase_ff : fphase_ff;
      p      = ph + 32'h4000_0000;
      mag    = p[31] ? (~p + 32'd1) : p;
      y      = prod_ff[60:29];
      e33    = neg_ff ? ({1'b0, HALF_TURN} - {1'b0, y}) : ({1'b0, HALF_TURN} + {1'b0, y});
      lvl_sh = level_ff[AB-1:15];
      ps     = prod_ff[40:15];

      case (cmd.op)
         geg_pkg::OP_MAP_S: begin
            mul_a = $signed({18'd0, shape_ff});
            mul_b = $signed({18'd0, SHARE_SCALE});
         end
         geg_pkg::OP_MAP_K: begin
            shape_m_in = prod_ff[31:16] + SHARE_BASE;
            mul_a = $signed({18'd0, skew_ff});
            mul_b = $signed({18'd0, SHARE_SCALE});
         end
         geg_pkg::OP_INIT: begin
            skew_m_in    = prod_ff[31:16] + SHARE_BASE;
            kind_in      = kind_req_ff;
            peak_in      = amp_ff;
            cnt_in       = '0;
            level_in     = '0;
            slope_in     = '0;
            change_in    = '0;
            rise_in      = '0;
            fall_in      = '0;
            att_end_in   = '0;
            rel_start_in = '0;
            rphase_in    = HALF_TURN;
            fphase_in    = '0;
         end
         geg_pkg::OP_P_SQ: begin
            mul_a = $signed({18'd0, len_ff});
            mul_b = $signed({18'd0, len_ff});
         end
         geg_pkg::OP_P_NUM: begin
            sq_in = prod_ff[31:0];
            mul_a = $signed({18'd0, amp_ff});
            mul_b = $signed({18'd0, (len_ff == '0) ? len_ff : (len_ff - 1'b1)});
         end
         geg_pkg::OP_P_DIV1: begin
            div_start    = 1'b1;
            div_dividend = {prod_ff[32:0], 17'd0};
            div_divisor  = sq_ff;
         end
         geg_pkg::OP_P_DIV2: begin
            slope_in     = geg_pkg::acc_from_quo(div_quo, div_zero);
            div_start    = 1'b1;
            div_dividend = {16'd0, amp_ff, 18'd0};
            div_divisor  = sq_ff;
         end
         geg_pkg::OP_P_END: begin
            change_in = AB'(0) - geg_pkg::acc_from_quo(div_quo, div_zero);
         end
         geg_pkg::OP_T_MID: begin
            mul_a = $signed({18'd0, len_ff});
            mul_b = $signed({18'd0, skew_m_ff});
         end
         geg_pkg::OP_T_DIV1: begin
            att_end_in   = mid_w;
            div_start    = 1'b1;
            div_dividend = {19'd0, amp_ff, 15'd0};
            div_divisor  = {16'd0, mid_w};
         end
         geg_pkg::OP_T_DIV2: begin
            rise_in      = geg_pkg::acc_from_quo(div_quo, div_zero);
            div_start    = 1'b1;
            div_dividend = {19'd0, amp_ff, 15'd0};
            div_divisor  = {16'd0, len_ff - att_end_ff};
         end
         geg_pkg::OP_T_END: begin
            fall_in = geg_pkg::acc_from_quo(div_quo, div_zero);
         end
         geg_pkg::OP_B_MULK: begin
            // signed skew offset from one half
            mul_a = $signed({18'd0, skew_m_ff}) - $signed(34'd32768);
            mul_b = $signed({18'd0, ratio_ff});
         end
         geg_pkg::OP_B_K2: begin
            k2_in = 16'(k2_t + 18'd32768);
            mul_a = $signed({18'd0, shape_m_ff});
            mul_b = $signed({18'd0, ratio_ff});
         end
         geg_pkg::OP_B_SRL: begin
            mul_a = $signed({1'b0, prod_ff[32:0]});
            mul_b = $signed({18'd0, len_ff});
         end
         geg_pkg::OP_B_SUS: begin
            sus_in = sus_w;
            mul_a  = $signed({18'd0, k2_ff});
            mul_b  = $signed({18'd0, len_ff - sus_w});
         end
         geg_pkg::OP_B_ATT: begin
            att_end_in   = att_w;
            rel_start_in = att_w + sus_ff;
            div_start    = 1'b1;
            div_dividend = {18'd0, HALF_TURN};
            div_divisor  = {16'd0, att_w};
         end
         geg_pkg::OP_B_RISE: begin
            rise_in      = geg_pkg::phase_from_quo(div_quo, div_zero);
            div_start    = 1'b1;
            div_dividend = {18'd0, HALF_TURN};
            div_divisor  = {16'd0, len_ff - rel_start_ff};
         end
         geg_pkg::OP_B_FALL: begin
            fall_in = geg_pkg::phase_from_quo(div_quo, div_zero);
         end
         geg_pkg::OP_S_PAR: begin
            level_in = geg_pkg::acc_add_sat(level_ff, slope_ff);
            slope_in = geg_pkg::acc_add_sat(slope_ff, change_ff);
         end
         geg_pkg::OP_S_TRI: begin
            if (in_attack) level_in = geg_pkg::acc_add_sat(level_ff, rise_ff);
            else           level_in = geg_pkg::acc_sub_sat(level_ff, fall_ff);
         end
         geg_pkg::OP_S_UNIT: begin
            level_in = AB'(1) << geg_pkg::ACC_FRAC_BITS;
         end
         geg_pkg::OP_S_BELL1: begin
            if (in_sustain) begin
               level_in = {{(AB-31){1'b0}}, peak_ff, 15'd0};
            end else begin
               if (in_attack) rphase_in = rphase_ff + rise_ff[31:0];
               else           fphase_in = fphase_ff + fall_ff[31:0];
               neg_in = p[31];
               mul_a  = $signed({2'd0, mag});
               mul_b  = $signed({2'd0, HALF_TURN - mag});
            end
         end
         geg_pkg::OP_S_BELL2: begin
            mul_a = $signed({18'd0, peak_ff});
            mul_b = $signed({2'd0, e33[32:1]});
         end
         geg_pkg::OP_S_BELL3: begin
            level_in = {{(AB-32){1'b0}}, prod_ff[47:16]};
         end
         geg_pkg::OP_OUT1: begin
            if (lvl_sh[24:16] == {9{lvl_sh[16]}})
               lev_in = lvl_sh[16:0];
            else
               lev_in = lvl_sh[24] ? 17'h10000 : 17'h0FFFF;
            if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
            mul_a = MB'(smp_ff);
            mul_b = MB'($signed(lev_in));
         end
         geg_pkg::OP_OUT2: begin
            if (ps[25:15] == {11{ps[15]}})
               out_smp_in = ps[15:0];
            else
               out_smp_in = ps[25] ? 16'h8000 : 16'h7FFF;
            out_lev_in   = lev_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= '0;
         peak_ff      <= '0;
         cnt_ff       <= '0;
         level_ff     <= '0;
         slope_ff     <= '0;
         change_ff    <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         att_end_ff   <= '0;
         rel_start_ff <= '0;
         rphase_ff    <= '0;
         fphase_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         peak_ff      <= peak_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         slope_ff     <= slope_in;
         change_ff    <= change_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         att_end_ff   <= att_end_in;
         rel_start_ff <= rel_start_in;
         rphase_ff    <= rphase_in;
         fphase_ff    <= fphase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         cmd_ff      <= req_cmd;
         smp_ff      <= req_sample_in;
         kind_req_ff <= req_env_kind;
         len_ff      <= req_grain_length;
         ratio_ff    <= req_length_ratio;
         shape_ff    <= req_shape_amount;
         skew_ff     <= req_skew_amount;
         amp_ff      <= req_amplitude;
      end
      shape_m_ff <= shape_m_in;
      skew_m_ff  <= skew_m_in;
      k2_ff      <= k2_in;
      sus_ff     <= sus_in;
      sq_ff      <= sq_in;
      neg_ff     <= neg_in;
      lev_ff     <= lev_in;
      // product holds through idle and wait cycles
      if (cmd.op != geg_pkg::OP_NONE) prod_ff <= mul_a * mul_b;
      out_smp_ff <= out_smp_in;
      out_lev_ff <= out_lev_in;
   end

   always_comb begin
      status.cmd        = cmd_ff;
      status.start_kind = kind_req_ff;
      status.kind       = kind_ff;
      status.div_busy   = div_busy;
      status.bell_flat  = in_sustain;
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = $signed(out_smp_ff);
   assign rsp_envelope_level = $signed(out_lev_ff);

endmodule
`default_nettype wire

// ----- rtl/core/grain_envelope_generator.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Grain envelope generator
// Top level: controller plus datapath for per-sample grain enveloping.
// ---------------------------------------------------------------------------
// A start transaction (req_cmd 0) loads kind, length, ratio, shape, skew and
// amplitude and turns them into per-sample steps; it returns no response. For
// the parabola, triangle and bell it runs two divisions after its multiply
// steps, bounded by the restoring divider at one quotient bit per cycle; the
// unity kind runs no division. A sample transaction (req_cmd 1) returns one
// response: the sample times the current envelope, Q1.15, saturated, together
// with the envelope gain. A sample runs through dispatch, its kind's update
// state (ST_S_BELL1 to ST_S_BELL3 on the bell's cosine slopes), ST_OUT1 and
// ST_OUT2 into the response register, using the single shared 34x34
// multiplier in sequence; the controller returns to idle for the next
// transaction as that register is filled. A finished response waits in its
// own register, so the next transaction is accepted while it is still
// pending on rsp_ready; a second sample then stalls until it drains.
// ---------------------------------------------------------------------------
module grain_envelope_generator (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_cmd,
   input  wire logic signed [geg_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic [1:0]                             req_env_kind,
   input  wire logic [geg_pkg::LENGTH_BITS-1:0]        req_grain_length,
   input  wire logic [15:0]                            req_length_ratio,
   input  wire logic [15:0]                            req_shape_amount,
   input  wire logic [15:0]                            req_skew_amount,
   input  wire logic [15:0]                            req_amplitude,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [geg_pkg::SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic signed [geg_pkg::LEVEL_BITS-1:0]       rsp_envelope_level
);

   // controller drives one datapath operation per cycle, none while it waits on the divider or a pending response
   geg_pkg::ctrl_cmd_type  cmd;
   geg_pkg::dp_status_type status;

   geg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds envelope state, multiplier, divider and response register
   geg_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_sample_in      (req_sample_in),
      .req_env_kind       (req_env_kind),
      .req_grain_length   (req_grain_length),
      .req_length_ratio   (req_length_ratio),
      .req_shape_amount   (req_shape_amount),
      .req_skew_amount    (req_skew_amount),
      .req_amplitude      (req_amplitude),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_envelope_level (rsp_envelope_level)
   );

endmodule
`default_nettype wire
